### rtl/ipt_pkg.sv
// shared constants, tables and types for the inverse park transform
`timescale 1ns / 1ps
package ipt_pkg;

	localparam int VOLT_BITS     = 16;
	localparam int ANGLE_BITS    = 16;
	localparam int CORDIC_STAGES = 16;
	localparam int XY_W          = 32;
	localparam int Z_W           = 32;
	localparam int TRIG_FRAC     = 15;
	localparam int TRIG_W        = TRIG_FRAC + 2;
	localparam int TRIG_ONE      = 2 ** TRIG_FRAC;
	localparam int PROD_W        = TRIG_W + VOLT_BITS;
	localparam int SUM_W         = PROD_W + 1;
	localparam int MIX_STAGES    = 3;
	localparam int PIPE_DEPTH    = CORDIC_STAGES + 2 + MIX_STAGES;
	localparam int S_TDATA_W     = ((2 * VOLT_BITS + ANGLE_BITS + 7) / 8) * 8;
	localparam int M_TDATA_W     = ((2 * VOLT_BITS + 7) / 8) * 8;

	localparam logic signed [XY_W-1:0] CORDIC_X0 = XY_W'(652032874);

	localparam logic signed [Z_W-1:0] ATAN_TURN [CORDIC_STAGES] = '{
		32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
		32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
		32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
		32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861
	};

	typedef struct packed {
		logic signed [TRIG_W-1:0]    cos_v;
		logic signed [TRIG_W-1:0]    sin_v;
		logic signed [VOLT_BITS-1:0] volt_q;
		logic signed [VOLT_BITS-1:0] volt_d;
	} trig_t;

	typedef struct packed {
		logic signed [VOLT_BITS-1:0] volt_beta;
		logic signed [VOLT_BITS-1:0] volt_alpha;
	} result_t;

endpackage

### rtl/ipt_cordic.sv
// pipelined cordic rotator producing sine and cosine of the electrical angle
`timescale 1ns / 1ps
module ipt_cordic
	import ipt_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic signed [VOLT_BITS-1:0] volt_q,
	input  logic signed [VOLT_BITS-1:0] volt_d,
	input  logic [ANGLE_BITS-1:0]       elec_angle,
	output logic                        out_valid,
	output trig_t                       trig
);

	localparam logic [1:0] QUAD_0 = 2'd0;
	localparam logic [1:0] QUAD_1 = 2'd1;
	localparam logic [1:0] QUAD_2 = 2'd2;
	localparam logic [Z_W-1:0] QUAD_HALF = Z_W'(1) << (Z_W - 3);
	localparam logic signed [XY_W:0] TRIG_HALF = (XY_W + 1)'(1) << (TRIG_FRAC - 1);
	localparam logic signed [XY_W:0] T_MAX = (XY_W + 1)'(TRIG_ONE);
	localparam logic signed [XY_W:0] T_MIN = -T_MAX;

	function automatic logic signed [TRIG_W-1:0] clamp_trig(input logic signed [XY_W-1:0] v);
		logic signed [XY_W:0] w;
		w = $signed({v[XY_W-1], v}) + TRIG_HALF;
		w = w >>> TRIG_FRAC;
		if (w < T_MIN) begin
			w = T_MIN;
		end else if (w > T_MAX) begin
			w = T_MAX;
		end
		return TRIG_W'(w);
	endfunction

	logic [CORDIC_STAGES:0]      v_s;
	logic signed [XY_W-1:0]      x_s  [CORDIC_STAGES+1];
	logic signed [XY_W-1:0]      y_s  [CORDIC_STAGES+1];
	logic signed [Z_W-1:0]       z_s  [CORDIC_STAGES+1];
	logic [1:0]                  quad_s [CORDIC_STAGES+1];
	logic signed [VOLT_BITS-1:0] vq_s [CORDIC_STAGES+1];
	logic signed [VOLT_BITS-1:0] vd_s [CORDIC_STAGES+1];

	logic signed [XY_W-1:0] x_nx [CORDIC_STAGES];
	logic signed [XY_W-1:0] y_nx [CORDIC_STAGES];
	logic signed [Z_W-1:0]  z_nx [CORDIC_STAGES];

	logic [Z_W-1:0]           ang_full;
	logic [Z_W-1:0]           ang_bias;
	logic [Z_W-1:0]           resid;
	logic [1:0]               quad_in;
	logic signed [TRIG_W-1:0] cos_r;
	logic signed [TRIG_W-1:0] sin_r;
	trig_t                    trig_nx;
	logic                     tv_s;
	trig_t                    trig_s;

	always_comb begin
		ang_full = Z_W'(elec_angle) << (Z_W - ANGLE_BITS);
		ang_bias = ang_full + QUAD_HALF;
		quad_in  = ang_bias[Z_W-1 -: 2];
		resid    = ang_full - {quad_in, {(Z_W - 2){1'b0}}};
	end

	always_comb begin
		for (int k = 0; k < CORDIC_STAGES; k++) begin
			if (!z_s[k][Z_W-1]) begin
				x_nx[k] = x_s[k] - (y_s[k] >>> k);
				y_nx[k] = y_s[k] + (x_s[k] >>> k);
				z_nx[k] = z_s[k] - ATAN_TURN[k];
			end else begin
				x_nx[k] = x_s[k] + (y_s[k] >>> k);
				y_nx[k] = y_s[k] - (x_s[k] >>> k);
				z_nx[k] = z_s[k] + ATAN_TURN[k];
			end
		end
	end

	always_comb begin
		cos_r = clamp_trig(x_s[CORDIC_STAGES]);
		sin_r = clamp_trig(y_s[CORDIC_STAGES]);
		trig_nx.volt_q = vq_s[CORDIC_STAGES];
		trig_nx.volt_d = vd_s[CORDIC_STAGES];
		case (quad_s[CORDIC_STAGES])
			QUAD_0: begin
				trig_nx.cos_v = cos_r;
				trig_nx.sin_v = sin_r;
			end
			QUAD_1: begin
				trig_nx.cos_v = -sin_r;
				trig_nx.sin_v = cos_r;
			end
			QUAD_2: begin
				trig_nx.cos_v = -cos_r;
				trig_nx.sin_v = -sin_r;
			end
			default: begin
				trig_nx.cos_v = sin_r;
				trig_nx.sin_v = -cos_r;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s  <= '0;
			tv_s <= 1'b0;
		end else if (en) begin
			v_s  <= {v_s[CORDIC_STAGES-1:0], in_valid};
			tv_s <= v_s[CORDIC_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]    <= CORDIC_X0;
			y_s[0]    <= '0;
			z_s[0]    <= $signed(resid);
			quad_s[0] <= quad_in;
			vq_s[0]   <= volt_q;
			vd_s[0]   <= volt_d;
			for (int k = 0; k < CORDIC_STAGES; k++) begin
				x_s[k+1]    <= x_nx[k];
				y_s[k+1]    <= y_nx[k];
				z_s[k+1]    <= z_nx[k];
				quad_s[k+1] <= quad_s[k];
				vq_s[k+1]   <= vq_s[k];
				vd_s[k+1]   <= vd_s[k];
			end
			trig_s <= trig_nx;
		end
	end

	assign out_valid = tv_s;
	assign trig      = trig_s;

endmodule

### rtl/ipt_mix.sv
// multiply, sum, round and saturate stages of the inverse park transform
`timescale 1ns / 1ps
module ipt_mix
	import ipt_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    en,
	input  logic    in_valid,
	input  trig_t   trig,
	output logic    out_valid,
	output result_t res
);

	localparam int RND_W = SUM_W + 1;
	localparam logic signed [RND_W-1:0] RND_HALF = RND_W'(1) << (TRIG_FRAC - 1);
	localparam logic signed [RND_W-1:0] V_MAX = RND_W'((1 << (VOLT_BITS - 1)) - 1);
	localparam logic signed [RND_W-1:0] V_MIN = ~V_MAX;

	function automatic logic signed [VOLT_BITS-1:0] round_sat(input logic signed [SUM_W-1:0] v);
		logic signed [RND_W-1:0] w;
		w = $signed({v[SUM_W-1], v}) + RND_HALF;
		w = w >>> TRIG_FRAC;
		if (w < V_MIN) begin
			w = V_MIN;
		end else if (w > V_MAX) begin
			w = V_MAX;
		end
		return VOLT_BITS'(w);
	endfunction

	logic                     v_s1;
	logic                     v_s2;
	logic                     v_s3;
	logic signed [PROD_W-1:0] p_cd_s1;
	logic signed [PROD_W-1:0] p_sq_s1;
	logic signed [PROD_W-1:0] p_sd_s1;
	logic signed [PROD_W-1:0] p_cq_s1;
	logic signed [SUM_W-1:0]  sum_a_s2;
	logic signed [SUM_W-1:0]  sum_b_s2;
	result_t                  res_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_cd_s1 <= $signed(trig.cos_v) * $signed(trig.volt_d);
			p_sq_s1 <= $signed(trig.sin_v) * $signed(trig.volt_q);
			p_sd_s1 <= $signed(trig.sin_v) * $signed(trig.volt_d);
			p_cq_s1 <= $signed(trig.cos_v) * $signed(trig.volt_q);
			sum_a_s2 <= $signed({p_cd_s1[PROD_W-1], p_cd_s1})
				- $signed({p_sq_s1[PROD_W-1], p_sq_s1});
			sum_b_s2 <= $signed({p_sd_s1[PROD_W-1], p_sd_s1})
				+ $signed({p_cq_s1[PROD_W-1], p_cq_s1});
			res_s3.volt_alpha <= round_sat(sum_a_s2);
			res_s3.volt_beta  <= round_sat(sum_b_s2);
		end
	end

	assign out_valid = v_s3;
	assign res       = res_s3;

endmodule

### rtl/inverse_park_transform_unit.sv
// inverse park transform top level: cordic sine/cosine, mixing and output skid stage
// a result passes the 18-stage cordic pipe, 3-stage multiply pipe and output register
// throughput: one word per cycle, held off while a result waits in the skid entry
// a two-entry output register keeps accepting while one result waits to be taken
// reset clears only the valid flags; data registers hold whatever they had
`timescale 1ns / 1ps
module inverse_park_transform_unit
	import ipt_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [S_TDATA_W-1:0] s_axis_tdata,  // volt_q, volt_d, elec_angle
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [M_TDATA_W-1:0] m_axis_tdata   // volt_alpha, volt_beta
);

	logic    en;
	logic    push;
	logic    trig_v;
	trig_t   trig;
	logic    pipe_v;
	result_t pipe_res;
	logic    out_v_q;
	result_t out_d_q;
	logic    skid_v_q;
	result_t skid_d_q;

	assign en            = !skid_v_q;
	assign push          = en && pipe_v;
	assign s_axis_tready = en;

	ipt_cordic u_cordic (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (s_axis_tvalid),
		.volt_q     (s_axis_tdata[VOLT_BITS-1:0]),
		.volt_d     (s_axis_tdata[2*VOLT_BITS-1:VOLT_BITS]),
		.elec_angle (s_axis_tdata[2*VOLT_BITS+ANGLE_BITS-1:2*VOLT_BITS]),
		.out_valid  (trig_v),
		.trig       (trig)
	);

	ipt_mix u_mix (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (trig_v),
		.trig      (trig),
		.out_valid (pipe_v),
		.res       (pipe_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || m_axis_tready) begin
			out_v_q  <= skid_v_q || push;
			skid_v_q <= 1'b0;
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || m_axis_tready) begin
			out_d_q <= skid_v_q ? skid_d_q : pipe_res;
		end else if (push) begin
			skid_d_q <= pipe_res;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = M_TDATA_W'(out_d_q);

endmodule

### rtl/ipt_checker.sv
// port-level checks for the inverse park transform unit and their binding
`timescale 1ns / 1ps
module ipt_checker
	import ipt_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_axis_tvalid,
	input logic                 s_axis_tready,
	input logic                 m_axis_tvalid,
	input logic                 m_axis_tready,
	input logic [M_TDATA_W-1:0] m_axis_tdata
);

	localparam int CAPACITY = PIPE_DEPTH + 2;
	localparam int OCC_W    = $clog2(CAPACITY + 1);

	logic [OCC_W-1:0] occ_q;
	logic             word_in;
	logic             word_out;

	assign word_in  = s_axis_tvalid && s_axis_tready;
	assign word_out = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (word_in && !word_out) begin
			occ_q <= occ_q + OCC_W'(1);
		end else if (word_out && !word_in) begin
			occ_q <= occ_q - OCC_W'(1);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result word changed while stalled");

	a_busy_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("input stalled without a waiting result");

	a_occ_cap: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_W'(CAPACITY))
		else $error("words in flight exceed capacity");

	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q == '0 |-> !m_axis_tvalid)
		else $error("result word with nothing in flight");

endmodule

bind inverse_park_transform_unit ipt_checker u_ipt_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

### sim/tb_top.sv
// self-checking testbench for the inverse park transform unit
`timescale 1ns / 1ps
module tb_top;
	import ipt_pkg::*;

	localparam int RAND_WORDS       = 1200;
	localparam int DRAIN_AT         = 350;
	localparam int HOLD_AT          = 700;
	localparam int SINK_HOLD_CYCLES = 300;
	localparam int V_MAX_I          = 2 ** (VOLT_BITS - 1) - 1;
	localparam int V_MIN_I          = -(2 ** (VOLT_BITS - 1));
	localparam logic signed [VOLT_BITS-1:0] V_MAX = VOLT_BITS'(V_MAX_I);
	localparam logic signed [VOLT_BITS-1:0] V_MIN = VOLT_BITS'(V_MIN_I);
	localparam int OCT = 2 ** (ANGLE_BITS - 3);

	typedef struct packed {
		logic [ANGLE_BITS-1:0]       elec_angle;
		logic signed [VOLT_BITS-1:0] volt_d;
		logic signed [VOLT_BITS-1:0] volt_q;
	} cmd_word_t;

	typedef struct packed {
		logic    kn_a;
		logic    kn_b;
		result_t ab;
	} pin_t;

	typedef struct packed {
		cmd_word_t cmd;
		pin_t      pin;
	} dir_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [S_TDATA_W-1:0] s_axis_tdata;   // volt_q, volt_d, elec_angle
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [M_TDATA_W-1:0] m_axis_tdata;   // volt_alpha, volt_beta

	result_t  ab_due[$];
	pin_t     typed_ab[$];
	dir_row_t dir_rows[$];
	bit       sink_hold;
	int       src_calm;
	int       err_count;
	int       words_in;
	int       words_out;
	int       sat_count;
	int       in_stall_cycles;

	inverse_park_transform_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#10_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic longint clip(longint v, longint lo, longint hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	// cordic sine/cosine of the angle, then rotation of (d, q) into (alpha, beta)
	function automatic result_t ipt_expect(cmd_word_t w);
		logic [31:0] turn;
		logic [31:0] resid;
		logic [1:0]  quad;
		longint      x, y, z, dx, dy, c0, s0, c, s, vd, vq, sum_a, sum_b;
		int          i;
		result_t     r;
		turn  = 32'(w.elec_angle) << (32 - ANGLE_BITS);
		quad  = 2'((turn + 32'h2000_0000) >> 30);
		resid = turn - (32'(quad) << 30);
		z     = longint'(signed'(resid));
		x     = CORDIC_X0;
		y     = 0;
		for (i = 0; i < CORDIC_STAGES; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x = x - dx;
				y = y + dy;
				z = z - ATAN_TURN[i];
			end else begin
				x = x + dx;
				y = y - dy;
				z = z + ATAN_TURN[i];
			end
		end
		c0 = clip((x + 16384) >>> 15, -TRIG_ONE, TRIG_ONE);
		s0 = clip((y + 16384) >>> 15, -TRIG_ONE, TRIG_ONE);
		case (quad)
			2'd0: begin
				c = c0;
				s = s0;
			end
			2'd1: begin
				c = -s0;
				s = c0;
			end
			2'd2: begin
				c = -c0;
				s = -s0;
			end
			default: begin
				c = s0;
				s = -c0;
			end
		endcase
		vd    = w.volt_d;
		vq    = w.volt_q;
		sum_a = c * vd - s * vq;
		sum_b = s * vd + c * vq;
		r.volt_alpha = VOLT_BITS'(clip((sum_a + 16384) >>> 15, V_MIN_I, V_MAX_I));
		r.volt_beta  = VOLT_BITS'(clip((sum_b + 16384) >>> 15, V_MIN_I, V_MAX_I));
		return r;
	endfunction

	function automatic void add_row(int q, int d, int ang, bit kn_a, int a, bit kn_b, int b);
		dir_row_t e;
		e.cmd.volt_q        = VOLT_BITS'(q);
		e.cmd.volt_d        = VOLT_BITS'(d);
		e.cmd.elec_angle    = ANGLE_BITS'(ang);
		e.pin.kn_a          = kn_a;
		e.pin.kn_b          = kn_b;
		e.pin.ab.volt_alpha = VOLT_BITS'(a);
		e.pin.ab.volt_beta  = VOLT_BITS'(b);
		dir_rows.push_back(e);
	endfunction

	function automatic int src_gap();
		int r;
		if (src_calm > 0) begin
			src_calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 2) src_calm = $urandom_range(20, 80);
		if (r < 55) return 0;
		if (r < 80) return 1;
		if (r < 93) return $urandom_range(2, 4);
		if (r < 98) return $urandom_range(5, 15);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic signed [VOLT_BITS-1:0] rand_volt();
		int r, k;
		r = $urandom_range(0, 99);
		k = $urandom_range(0, 40);
		if (r < 60) return VOLT_BITS'($urandom);
		if (r < 75) return VOLT_BITS'(k * 8 - 160);
		if (r < 90) return VOLT_BITS'(r[0] ? V_MAX_I - k : V_MIN_I + k);
		return VOLT_BITS'(k % 3 - 1);
	endfunction

	// mostly uniform, the rest near octant and quadrant boundaries
	function automatic logic [ANGLE_BITS-1:0] rand_angle();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return ANGLE_BITS'($urandom);
		return ANGLE_BITS'(int'($urandom_range(0, 7)) * OCT + int'($urandom_range(0, 6)) - 3);
	endfunction

	// entered and left at a falling edge; valid stays high after the word is taken
	task automatic push_word(input cmd_word_t w, input pin_t pin);
		int gap;
		gap = src_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		typed_ab.push_back(pin);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= w;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	initial begin
		int        n;
		cmd_word_t w;
		pin_t      no_pin;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		no_pin        = '0;
		// zero command gives zero output at any angle
		add_row(0, 0, 0, 1, 0, 1, 0);
		add_row(0, 0, 16384, 1, 0, 1, 0);
		add_row(0, 0, 32768, 1, 0, 1, 0);
		add_row(0, 0, 65535, 1, 0, 1, 0);
		// 45 degree multiples with full-scale commands saturate one axis; the later rows pin no result
		add_row(32767, 32767, 8192, 0, 0, 1, V_MAX_I);
		add_row(-32768, 32767, 8192, 1, V_MAX_I, 0, 0);
		add_row(-32768, -32768, 8192, 0, 0, 1, V_MIN_I);
		add_row(32767, -32768, 8192, 1, V_MIN_I, 0, 0);
		add_row(32767, -32768, 24576, 0, 0, 1, V_MIN_I);
		add_row(32767, 32767, 40960, 0, 0, 1, V_MIN_I);
		add_row(-32768, 32767, 57344, 0, 0, 1, V_MIN_I);
		add_row(32767, -32768, 0, 0, 0, 0, 0);
		add_row(-32768, 32767, 16384, 0, 0, 0, 0);
		add_row(12345, -23456, 8191, 0, 0, 0, 0);
		add_row(-1, 1, 8192, 0, 0, 0, 0);
		add_row(1, -1, 65535, 0, 0, 0, 0);
		add_row(32767, 32767, 1, 0, 0, 0, 0);
		add_row(-32768, -32768, 32767, 0, 0, 0, 0);
		add_row(20000, 0, 49152, 0, 0, 0, 0);
		add_row(0, 20000, 24575, 0, 0, 0, 0);
		add_row(-32768, 32767, 40959, 0, 0, 0, 0);
		add_row(100, -100, 57343, 0, 0, 0, 0);
		add_row(21845, -21846, 43690, 0, 0, 0, 0);
		add_row(-21846, 21845, 21845, 0, 0, 0, 0);
		@(posedge arst_n);
		@(negedge clk);
		foreach (dir_rows[i]) push_word(dir_rows[i].cmd, dir_rows[i].pin);
		for (n = 0; n < RAND_WORDS; n++) begin
			if (n == DRAIN_AT) begin
				s_axis_tvalid <= 1'b0;
				do @(negedge clk); while (ab_due.size() != 0);
			end
			if (n == HOLD_AT) sink_hold = 1'b1;
			w.volt_q     = rand_volt();
			w.volt_d     = rand_volt();
			w.elec_angle = rand_angle();
			push_word(w, no_pin);
		end
		s_axis_tvalid <= 1'b0;
		while (ab_due.size() != 0) @(posedge clk);
		repeat (PIPE_DEPTH + 8) @(posedge clk);
		$display("%0d command words (%0d table rows, %0d random), %0d result words compared",
			words_in, dir_rows.size(), RAND_WORDS, words_out);
		$display("%0d results at a saturation limit, input held off for %0d cycles",
			sat_count, in_stall_cycles);
		if (err_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	initial begin
		int r, stall_left, calm_left;
		bit hold_done;
		m_axis_tready = 1'b0;
		stall_left    = 0;
		calm_left     = 0;
		hold_done     = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (sink_hold && !hold_done) begin
				m_axis_tready <= 1'b0;
				repeat (SINK_HOLD_CYCLES) @(negedge clk);
				hold_done = 1'b1;
				m_axis_tready <= 1'b1;
			end else if (calm_left > 0) begin
				calm_left--;
				m_axis_tready <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 2) calm_left = $urandom_range(20, 100);
				else if (r < 5) stall_left = $urandom_range(5, 40);
				m_axis_tready <= (r >= 25);
			end
		end
	end

	always @(posedge clk) begin : word_monitor
		pin_t    pin;
		result_t want;
		result_t got;
		if (arst_n) begin
			if (s_axis_tvalid && !s_axis_tready) in_stall_cycles++;
			if (s_axis_tvalid && s_axis_tready) begin
				want = ipt_expect(cmd_word_t'(s_axis_tdata));
				if (typed_ab.size() != 0) begin
					pin = typed_ab.pop_front();
					if (pin.kn_a) want.volt_alpha = pin.ab.volt_alpha;
					if (pin.kn_b) want.volt_beta = pin.ab.volt_beta;
				end
				ab_due.push_back(want);
				words_in++;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got = result_t'(m_axis_tdata);
				words_out++;
				if (ab_due.size() == 0) begin
					$error("unexpected result word: volt_alpha %0d, volt_beta %0d",
						got.volt_alpha, got.volt_beta);
					err_count++;
				end else begin
					want = ab_due.pop_front();
					if (got.volt_alpha !== want.volt_alpha) begin
						$error("volt_alpha: expected %0d, actual %0d",
							want.volt_alpha, got.volt_alpha);
						err_count++;
					end
					if (got.volt_beta !== want.volt_beta) begin
						$error("volt_beta: expected %0d, actual %0d",
							want.volt_beta, got.volt_beta);
						err_count++;
					end
					if (got.volt_alpha == V_MAX || got.volt_alpha == V_MIN ||
						got.volt_beta == V_MAX || got.volt_beta == V_MIN) sat_count++;
				end
			end
		end
	end

endmodule
